FILE: sv/smeter_pkg.sv
// Shared types and constants for the signal meter with bar and peak hold.
// Holds the S-unit segment tables and the config register index codes.
// No dependencies.
package smeter_pkg;

	localparam int LEVELW = 13;
	localparam int OFSW = 12;
	localparam int V16W = 15;
	localparam int DBMW = 11;
	localparam int BARW = 8;
	localparam int SEGS = 9;
	localparam int DIFFW = 14;
	localparam int RECIPW = 20;
	localparam int PRODW = DIFFW + RECIPW;
	localparam int RECIP_SHIFT = 22;
	localparam int QUOTW = PRODW - RECIP_SHIFT;
	localparam int SUMW = QUOTW + 1;

	typedef logic signed [V16W-1:0] v16_t;
	typedef logic [1:0] reg_idx_t;
	typedef logic [$clog2(SEGS)-1:0] seg_t;

	localparam reg_idx_t REG_CAL = 2'd0;
	localparam reg_idx_t REG_PREAMP = 2'd1;
	localparam reg_idx_t REG_HOLD = 2'd2;
	localparam reg_idx_t REG_MODE = 2'd3;

	localparam v16_t FILTER_OFFSET = 15'sd383;
	localparam logic [BARW-1:0] HOLD_RESET = 8'd10;

	// upper bound of each segment in 1/16 dB; last segment is open
	localparam v16_t SEG_UPPER [0:SEGS-2] = '{
		-15'sd1552, -15'sd1456, -15'sd1360, -15'sd1264,
		-15'sd1168, -15'sd848, -15'sd528, -15'sd208
	};

	localparam v16_t SEG_ORIGIN [0:SEGS-1] = '{
		-15'sd1600, -15'sd1552, -15'sd1456, -15'sd1360, -15'sd1264,
		-15'sd1168, -15'sd848, -15'sd528, -15'sd208
	};

	localparam logic [BARW-1:0] SEG_BASE [0:SEGS-1] = '{
		8'd0, 8'd10, 8'd27, 8'd43, 8'd60, 8'd76, 8'd100, 8'd124, 8'd148
	};

	// ceil(slope * 2^22 / (16 * span)); exact floor for offsets below 2^14
	localparam logic [RECIPW-1:0] SEG_RECIP [0:SEGS-1] = '{
		RECIPW'(((10 << RECIP_SHIFT) + 47) / 48),
		RECIPW'(((17 << RECIP_SHIFT) + 95) / 96),
		RECIPW'(((16 << RECIP_SHIFT) + 95) / 96),
		RECIPW'(((17 << RECIP_SHIFT) + 95) / 96),
		RECIPW'(((16 << RECIP_SHIFT) + 95) / 96),
		RECIPW'(((24 << RECIP_SHIFT) + 319) / 320),
		RECIPW'(((24 << RECIP_SHIFT) + 319) / 320),
		RECIPW'(((24 << RECIP_SHIFT) + 319) / 320),
		RECIPW'(((19 << RECIP_SHIFT) + 319) / 320)
	};

endpackage

FILE: sv/signal_meter_bar_peak_hold.sv
// Signal meter: level to dBm, S-unit bar position and held peak marker.
// Depends on smeter_pkg.
//
// Usage:
//   Input channel: level (1/16 dB, signed) with in_valid / in_stall.
//   Output channel: shown, dbm_value, bar_position, peak_position with
//   out_valid / out_stall. A word moves when valid is high and stall low.
//   Config: cfg_we writes cfg_data into register cfg_index (0 calibration
//   offset, 1 preamp offset, 2 peak hold length, 3 mode); write while idle.
//   A word goes from the input register to the output registers, where
//   out_valid rises. One word is taken per cycle while in_stall is low;
//   the segment lookup, one 14x20 constant-reciprocal multiply and the
//   peak compare sit between the input and output registers.
//   When the receiver stalls, the output word holds and one more word is
//   taken into the input register; then in_stall rises until the output
//   moves.
//   Reset clears both pipeline valids, the peak and hold counter, and sets
//   the registers to offsets 0, hold length 10, metering on.
//   In off mode words pass through with shown low and zero fields; the
//   peak state is left as it was.
module signal_meter_bar_peak_hold (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [smeter_pkg::LEVELW-1:0]  level,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  shown,
	output logic signed [smeter_pkg::DBMW-1:0]    dbm_value,
	output logic [smeter_pkg::BARW-1:0]           bar_position,
	output logic [smeter_pkg::BARW-1:0]           peak_position,
	input  logic                                  cfg_we,
	input  smeter_pkg::reg_idx_t                  cfg_index,
	input  logic [smeter_pkg::OFSW-1:0]           cfg_data
);
	import smeter_pkg::*;

	logic signed [OFSW-1:0] cal_q;
	logic signed [OFSW-1:0] preamp_q;
	logic [BARW-1:0]        hold_len_q;
	logic                   mode_q;
	logic [BARW-1:0]        peak_q;
	logic [BARW-1:0]        hold_cnt_q;

	logic valid_s1;
	v16_t v16_s1;

	logic adv_out;
	logic take_in;

	seg_t                   seg;
	logic signed [V16W:0]   diff;
	logic [PRODW-1:0]       prod;
	logic [QUOTW-1:0]       quot;
	logic [SUMW-1:0]        bar_sum;
	logic [BARW-1:0]        bar;
	v16_t                   rnd;
	logic signed [DBMW-1:0] dbm;
	logic [BARW-1:0]        peak_up;
	logic [BARW-1:0]        cnt_up;
	logic [BARW-1:0]        peak_nxt;
	logic [BARW-1:0]        cnt_nxt;

	assign adv_out = !out_valid || !out_stall;
	assign take_in = !valid_s1 || adv_out;
	assign in_stall = !take_in;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
			preamp_q <= '0;
			hold_len_q <= HOLD_RESET;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAL: cal_q <= cfg_data;
				REG_PREAMP: preamp_q <= cfg_data;
				REG_HOLD: hold_len_q <= cfg_data[BARW-1:0];
				REG_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input stage: corrected level in 1/16 dB
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in && in_valid) begin
			v16_s1 <= V16W'(level) + V16W'(cal_q) + V16W'(preamp_q) + FILTER_OFFSET;
		end
	end

	// bar mapping, dBm and peak update
	always_comb begin
		seg = '0;
		for (int i = 0; i < SEGS - 1; i++) begin
			if (v16_s1 > SEG_UPPER[i]) begin
				seg = seg_t'(i + 1);
			end
		end
		diff = (V16W+1)'(v16_s1) - (V16W+1)'(SEG_ORIGIN[seg]);
		prod = PRODW'(diff[DIFFW-1:0]) * PRODW'(SEG_RECIP[seg]);
		quot = prod[PRODW-1:RECIP_SHIFT];
		bar_sum = SUMW'(SEG_BASE[seg]) + SUMW'(quot);
		if (diff[V16W] || bar_sum == '0) begin
			bar = BARW'(1);
		end else if (bar_sum > SUMW'(255)) begin
			bar = BARW'(255);
		end else begin
			bar = bar_sum[BARW-1:0];
		end

		// truncate toward zero
		rnd = v16_s1 + (v16_s1[V16W-1] ? 15'sd15 : 15'sd0);
		dbm = DBMW'(rnd >>> 4);

		if (bar > peak_q) begin
			peak_up = bar;
			cnt_up = '0;
		end else begin
			peak_up = peak_q;
			cnt_up = hold_cnt_q;
		end
		if (cnt_up >= hold_len_q) begin
			peak_nxt = bar;
			cnt_nxt = '0;
		end else begin
			peak_nxt = peak_up;
			cnt_nxt = cnt_up + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			peak_q <= '0;
			hold_cnt_q <= '0;
		end else if (adv_out) begin
			out_valid <= valid_s1;
			if (valid_s1 && !mode_q) begin
				peak_q <= peak_nxt;
				hold_cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			if (mode_q) begin
				shown <= 1'b0;
				dbm_value <= '0;
				bar_position <= '0;
				peak_position <= '0;
			end else begin
				shown <= 1'b1;
				dbm_value <= dbm;
				bar_position <= bar;
				peak_position <= peak_nxt;
			end
		end
	end

`ifndef ASSERT_OFF
	a_bar_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shown |-> bar_position != '0)
		else $error("bar position zero while shown");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !shown |-> dbm_value == '0 && bar_position == '0 && peak_position == '0)
		else $error("fields not cleared in off mode");

	a_peak_ge_bar: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shown |-> peak_position >= bar_position)
		else $error("peak marker below bar");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with room in pipeline");

	a_peak_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_out && valid_s1 && mode_q |=> $stable(peak_q) && $stable(hold_cnt_q))
		else $error("peak state changed in off mode");
`endif

endmodule

FILE: test/tb_signal_meter_bar_peak_hold.sv
// Testbench for signal_meter_bar_peak_hold: directed table, then random phases of level words.
// Checks each result word against a typed row or an in-bench S-meter predictor with peak hold.
// Depends on smeter_pkg and the signal_meter_bar_peak_hold RTL.
module tb_signal_meter_bar_peak_hold;
	import smeter_pkg::*;

	localparam int NDIR = 34;
	localparam int NPHASE = 8;
	localparam int PHASE_WORDS = 200;

	// segment tables in 1/16 dB
	localparam int BOUND16 [0:7] = '{-1552, -1456, -1360, -1264, -1168, -848, -528, -208};
	localparam int ORG16 [0:8] = '{-1600, -1552, -1456, -1360, -1264, -1168, -848, -528, -208};
	localparam int BAR_BASE [0:8] = '{0, 10, 27, 43, 60, 76, 100, 124, 148};
	localparam int BAR_SLOPE [0:8] = '{10, 17, 16, 17, 16, 24, 24, 24, 19};
	localparam int BAR_SPAN [0:8] = '{3, 6, 6, 6, 6, 20, 20, 20, 20};

	typedef struct packed {
		logic shown;
		logic signed [DBMW-1:0] dbm;
		logic [BARW-1:0] bar;
		logic [BARW-1:0] peak;
	} reading_t;

	typedef struct packed {
		logic is_cfg;
		reg_idx_t idx;
		logic [OFSW-1:0] data;
		logic signed [LEVELW-1:0] lvl;
		logic typed;
		reading_t want;
	} step_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [LEVELW-1:0] level = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic shown;
	logic signed [DBMW-1:0] dbm_value;
	logic [BARW-1:0] bar_position;
	logic [BARW-1:0] peak_position;
	logic cfg_we = 1'b0;
	reg_idx_t cfg_index = REG_CAL;
	logic [OFSW-1:0] cfg_data = '0;

	// predictor state and register copies
	logic signed [OFSW-1:0] cal_ofs = '0;
	logic signed [OFSW-1:0] pre_ofs = '0;
	logic [BARW-1:0] hold_len = HOLD_RESET;
	logic meter_off = 1'b0;
	logic [BARW-1:0] held_peak = '0;
	logic [BARW-1:0] hold_cnt = '0;

	reading_t pending_q [$];
	bit calm = 1'b0;
	int err_cnt = 0;
	int words_sent = 0;
	int words_seen = 0;
	int settings_cnt = 0;

	signal_meter_bar_peak_hold i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.level(level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.shown(shown),
		.dbm_value(dbm_value),
		.bar_position(bar_position),
		.peak_position(peak_position),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_error(input string what);
		if (err_cnt < 10) begin
			$display("ERROR @%0t: %s", $realtime, what);
		end
		err_cnt++;
	endtask

	function automatic reading_t predict_reading(input logic signed [LEVELW-1:0] lvl);
		int v16;
		int k;
		int num;
		int x;
		reading_t r;
		r = '0;
		if (meter_off) begin
			return r;
		end
		v16 = int'(lvl) + int'(cal_ofs) + int'(pre_ofs) + 383;
		k = 0;
		while (k < 8 && v16 > BOUND16[k]) begin
			k++;
		end
		num = (v16 - ORG16[k]) * BAR_SLOPE[k];
		if (num < 0) begin
			x = 1;
		end else begin
			x = BAR_BASE[k] + num / (BAR_SPAN[k] * 16);
		end
		if (x <= 0) begin
			x = 1;
		end
		if (x > 255) begin
			x = 255;
		end
		if (BARW'(x) > held_peak) begin
			held_peak = BARW'(x);
			hold_cnt = '0;
		end
		if (hold_cnt >= hold_len) begin
			held_peak = BARW'(x);
			hold_cnt = '0;
		end else begin
			hold_cnt = hold_cnt + 1'b1;
		end
		r.shown = 1'b1;
		r.dbm = DBMW'(v16 / 16);
		r.bar = BARW'(x);
		r.peak = held_peak;
		return r;
	endfunction

	function automatic step_t item_row(input logic signed [LEVELW-1:0] lvl);
		step_t s;
		s = '0;
		s.lvl = lvl;
		return s;
	endfunction

	function automatic step_t typed_row(input logic signed [LEVELW-1:0] lvl, input logic sh,
			input logic signed [DBMW-1:0] dbm, input logic [BARW-1:0] bar,
			input logic [BARW-1:0] peak);
		step_t s;
		s = '0;
		s.lvl = lvl;
		s.typed = 1'b1;
		s.want.shown = sh;
		s.want.dbm = dbm;
		s.want.bar = bar;
		s.want.peak = peak;
		return s;
	endfunction

	function automatic step_t cfg_row(input reg_idx_t idx, input logic [OFSW-1:0] data);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.data = data;
		return s;
	endfunction

	function automatic logic [OFSW-1:0] pick_offset();
		case ($urandom_range(0, 3))
			0: pick_offset = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
			1: pick_offset = OFSW'($urandom);
			default: pick_offset = OFSW'($urandom_range(0, 320) - 160);
		endcase
	endfunction

	task automatic send_word(input logic signed [LEVELW-1:0] lvl, input logic typed,
			input reading_t want);
		reading_t r;
		while (!calm && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			level <= LEVELW'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		level <= lvl;
		do @(posedge clk); while (in_stall);
		r = predict_reading(lvl);
		pending_q.push_back(typed ? want : r);
		words_sent++;
	endtask

	// registers change only with the pipeline empty
	task automatic write_reg(input reg_idx_t idx, input logic [OFSW-1:0] data);
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CAL: cal_ofs = data;
			REG_PREAMP: pre_ofs = data;
			REG_HOLD: hold_len = data[BARW-1:0];
			REG_MODE: meter_off = data[0];
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 32);
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			words_seen++;
			if (pending_q.size() == 0) begin
				report_error("result word with nothing expected");
			end else begin
				want = pending_q.pop_front();
				if (shown !== want.shown || dbm_value !== want.dbm
						|| bar_position !== want.bar || peak_position !== want.peak) begin
					report_error($sformatf(
						"exp shown %0b dbm %0d bar %0d peak %0d, got shown %0b dbm %0d bar %0d peak %0d",
						want.shown, $signed(want.dbm), want.bar, want.peak,
						shown, dbm_value, bar_position, peak_position));
				end
			end
		end
	end

	initial begin
		step_t dir_tab [NDIR];
		logic signed [LEVELW-1:0] lvl;
		logic [BARW-1:0] hold;
		int walk;
		int v16;
		int t;
		int k;
		int pick;
		int guard;

		dir_tab = '{
			typed_row(-13'sd4096, 1'b1, -11'sd232, 8'd1, 8'd1),
			typed_row(13'sd4095, 1'b1, 11'sd279, 8'd255, 8'd255),
			item_row(13'sd0),
			item_row(-13'sd1984),
			item_row(-13'sd1983),
			item_row(-13'sd1935),
			item_row(-13'sd1934),
			item_row(-13'sd1839),
			item_row(-13'sd1743),
			item_row(-13'sd1647),
			item_row(-13'sd1551),
			item_row(-13'sd1231),
			item_row(-13'sd911),
			item_row(-13'sd591),
			item_row(-13'sd590),
			item_row(-13'sd400),
			cfg_row(REG_HOLD, 12'h000),
			typed_row(13'sd4095, 1'b1, 11'sd279, 8'd255, 8'd255),
			typed_row(-13'sd4096, 1'b1, -11'sd232, 8'd1, 8'd1),
			cfg_row(REG_CAL, 12'h800),
			cfg_row(REG_PREAMP, 12'h800),
			typed_row(-13'sd4096, 1'b1, -11'sd488, 8'd1, 8'd1),
			cfg_row(REG_CAL, 12'h7FF),
			cfg_row(REG_PREAMP, 12'h7FF),
			typed_row(13'sd4095, 1'b1, 11'sd535, 8'd255, 8'd255),
			cfg_row(REG_MODE, 12'h001),
			typed_row(13'sd4095, 1'b0, 11'sd0, 8'd0, 8'd0),
			typed_row(-13'sd4096, 1'b0, 11'sd0, 8'd0, 8'd0),
			cfg_row(REG_MODE, 12'hFFE),
			cfg_row(REG_CAL, 12'h000),
			cfg_row(REG_PREAMP, 12'h000),
			cfg_row(REG_HOLD, 12'h0FF),
			item_row(13'sd1000),
			item_row(-13'sd1000)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < NDIR; i++) begin
			if (dir_tab[i].is_cfg) begin
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else begin
				send_word(dir_tab[i].lvl, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		for (int ph = 0; ph < NPHASE; ph++) begin
			write_reg(REG_CAL, pick_offset());
			write_reg(REG_PREAMP, pick_offset());
			if ($urandom_range(0, 3) == 0) begin
				hold = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end else begin
				hold = BARW'($urandom_range(1, 24));
			end
			write_reg(REG_HOLD, {4'($urandom), hold});
			write_reg(REG_MODE, {11'($urandom), ph == 5});
			calm = (ph == 1);
			settings_cnt++;
			walk = -1200;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					lvl = LEVELW'($urandom);
				end else begin
					if (pick < 40) begin
						k = $urandom_range(0, 8);
						v16 = (k == 8 ? ORG16[0] : BOUND16[k]) + int'($urandom_range(0, 4)) - 2;
					end else begin
						// spikes followed by a slow decay exercise the hold counter
						if (pick < 48) begin
							walk = int'($urandom_range(0, 2400)) - 1700;
						end else begin
							walk = walk + int'($urandom_range(0, 48)) - 28;
						end
						if (walk < -1800) walk = -1800;
						if (walk > 700) walk = 700;
						v16 = walk;
					end
					t = v16 - int'(cal_ofs) - int'(pre_ofs) - 383;
					if (t < -4096) t = -4096;
					if (t > 4095) t = 4095;
					lvl = LEVELW'(t);
				end
				send_word(lvl, 1'b0, '0);
			end
			calm = 1'b0;
		end

		in_valid <= 1'b0;
		guard = 0;
		while (pending_q.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (pending_q.size() != 0) begin
			report_error($sformatf("%0d expected words never arrived", pending_q.size()));
		end

		$display("Sent %0d level words, checked %0d result words over %0d random settings",
			words_sent, words_seen, settings_cnt);
		$display("(offset extremes, hold lengths 0 to 255, off mode); %0d mismatches", err_cnt);
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/smeter_pkg.sv
sv/signal_meter_bar_peak_hold.sv
test/tb_signal_meter_bar_peak_hold.sv
